### rtl/core/first_fit_buffer_pool_core_defines.svh
// ----------------------------------------------------------------------------
// first_fit_buffer_pool_core_defines
// Assertion macros shared by the buffer pool RTL.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BUFFER_POOL_CORE_DEFINES_SVH
`define FIRST_FIT_BUFFER_POOL_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// checked property, quiet during reset
`define FFBP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// checked property, also during reset
`define FFBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FFBP_ASSERT(lbl, clk, rst_n, prop, msg)
`define FFBP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/core/ffbp_pkg.sv
// ----------------------------------------------------------------------------
// ffbp_pkg
// Widths, codes and shared types of the first-fit buffer pool.
// ----------------------------------------------------------------------------
package ffbp_pkg;

  localparam int HANDLE_W = 52;
  localparam int PAGES_W  = 21;
  localparam int LEN_W    = 32;

  typedef enum logic {
    ACT_REQ = 1'b0,
    ACT_RET = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_HIT    = 2'd0,
    ST_MISS   = 2'd1,
    ST_STORED = 2'd2,
    ST_EVICT  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PUSH,
    S_SEARCH
  } fsm_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [PAGES_W-1:0]  pages;
  } entry_t;

  // per-cycle commands broadcast to every cell
  typedef struct packed {
    logic load;  // token enters cell 0
    logic step;  // token moves one cell on
    logic pull;  // cells at or past the hit close the gap
    logic push;  // all cells shift one place toward the tail
    logic clr;   // drop token and search marks
  } ctl_t;

endpackage

### rtl/core/ffbp_in_if.sv
// ----------------------------------------------------------------------------
// ffbp_in_if
// Input channel: request or return word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ffbp_in_if import ffbp_pkg::*;;
  logic                valid;
  logic                ready;
  logic                action;
  logic [LEN_W-1:0]    req_length;
  logic [HANDLE_W-1:0] handle;
  logic [PAGES_W-1:0]  ret_pages;

  modport source (output valid, action, req_length, handle, ret_pages, input ready);
  modport sink   (input valid, action, req_length, handle, ret_pages, output ready);
endinterface

### rtl/core/ffbp_out_if.sv
// ----------------------------------------------------------------------------
// ffbp_out_if
// Result channel: status word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ffbp_out_if import ffbp_pkg::*;;
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [HANDLE_W-1:0] out_handle;
  logic [PAGES_W-1:0]  out_pages;

  modport source (output valid, status, out_handle, out_pages, input ready);
  modport sink   (input valid, status, out_handle, out_pages, output ready);
endinterface

### rtl/core/ffbp_cell.sv
// ----------------------------------------------------------------------------
// ffbp_cell
// One pool slot: holds an entry, carries the search token and its compare.
// ----------------------------------------------------------------------------
module ffbp_cell import ffbp_pkg::*; #(
  parameter int NEED_W = 21
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_t              ctl,
  input  logic              live,
  input  logic [NEED_W-1:0] need,
  input  logic              tok_in,
  input  entry_t            left_ent,
  input  entry_t            right_ent,
  output entry_t            ent,
  output logic              tok_out,
  output logic              hit
);

  localparam int CMP_W = (NEED_W > PAGES_W) ? NEED_W : PAGES_W;

  entry_t ent_r;
  logic   tok_r;
  logic   seen_r;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      ent_r <= left_ent;
    end else if (ctl.pull && !seen_r) begin
      ent_r <= right_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r  <= 1'b0;
      seen_r <= 1'b0;
    end else if (ctl.clr) begin
      tok_r  <= 1'b0;
      seen_r <= 1'b0;
    end else if (ctl.step) begin
      tok_r  <= tok_in;
      seen_r <= seen_r | tok_r;
    end
  end

  assign hit     = tok_r && live && (CMP_W'(need) <= CMP_W'(ent_r.pages));
  assign ent     = ent_r;
  assign tok_out = tok_r;

endmodule

### rtl/core/first_fit_buffer_pool_core.sv
// Return: the word passes S_PUSH, where the result is registered; then S_IDLE takes the next word.
// Request: token walks one cell per cycle; the result is registered when it hits or leaves the
// live entries; the walk length is the position of the first fit, or the entry count on a miss.
// One word in flight; input ready again as the result is registered.
// A result stalled at the output holds the chain.
// Synchronous active-low reset empties the pool; no clearing pass.
// ----------------------------------------------------------------------------
// first_fit_buffer_pool_core
// First-fit pool of freed page buffers, newest first, held in a cell chain.
// PAGE_BYTES must be a power of two.
// ----------------------------------------------------------------------------
`include "first_fit_buffer_pool_core_defines.svh"

module first_fit_buffer_pool_core import ffbp_pkg::*; #(
  parameter int POOL_DEPTH = 16,
  parameter int PAGE_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  ffbp_in_if.sink     in_ch,
  ffbp_out_if.source  out_ch
);

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int NEED_W     = LEN_W + 1 - PAGE_SHIFT;
  localparam int CMP_W      = (NEED_W > PAGES_W) ? NEED_W : PAGES_W;
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

  fsm_t                state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [NEED_W-1:0]   need_r;
  entry_t              item_r;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  entry_t              out_ent_r, out_ent_nxt;

  ctl_t                ctl;
  entry_t              ent [POOL_DEPTH];
  logic [POOL_DEPTH-1:0] tok, hit, live;
  entry_t              hit_ent;
  logic                in_fire, out_free, tok_live;
  logic [LEN_W:0]      len_sum;
  logic [PAGES_W-1:0]  miss_pages;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign len_sum     = {1'b0, in_ch.req_length} + (LEN_W + 1)'(PAGE_BYTES - 1);

  // cell chain
  for (genvar i = 0; i < POOL_DEPTH; i++) begin : g_cell
    assign live[i] = CNT_W'(i) < count_r;
    ffbp_cell #(.NEED_W(NEED_W)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .live      (live[i]),
      .need      (need_r),
      .tok_in    ((i == 0) ? ctl.load : tok[(i == 0) ? 0 : i - 1]),
      .left_ent  ((i == 0) ? item_r : ent[(i == 0) ? 0 : i - 1]),
      .right_ent ((i == POOL_DEPTH - 1) ? entry_t'('0)
                                        : ent[(i == POOL_DEPTH - 1) ? i : i + 1]),
      .ent       (ent[i]),
      .tok_out   (tok[i]),
      .hit       (hit[i])
    );
  end

  always_comb begin
    hit_ent = '0;
    for (int i = 0; i < POOL_DEPTH; i++) begin
      hit_ent = hit_ent | (ent[i] & {$bits(entry_t){hit[i]}});
    end
  end

  assign tok_live   = |(tok & live);
  assign miss_pages = (CMP_W'(need_r) > CMP_W'({PAGES_W{1'b1}})) ? {PAGES_W{1'b1}}
                                                                 : PAGES_W'(need_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      need_r       <= len_sum[LEN_W:PAGE_SHIFT];
      item_r       <= '{handle: in_ch.handle, pages: in_ch.ret_pages};
    end
    out_status_r <= out_status_nxt;
    out_ent_r    <= out_ent_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ctl            = '0;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_ent_nxt    = out_ent_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (action_t'(in_ch.action) == ACT_RET) begin
            state_nxt = S_PUSH;
          end else begin
            ctl.load  = 1'b1;
            ctl.step  = 1'b1;
            state_nxt = S_SEARCH;
          end
        end
      end
      S_PUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          ctl.push      = 1'b1;
          state_nxt     = S_IDLE;
          if (count_r == CNT_W'(POOL_DEPTH)) begin
            out_status_nxt = ST_EVICT;
            out_ent_nxt    = ent[POOL_DEPTH-1];
          end else begin
            out_status_nxt = ST_STORED;
            out_ent_nxt    = '0;
            count_nxt      = count_r + CNT_W'(1);
          end
        end
      end
      S_SEARCH: begin
        if (|hit) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_HIT;
            out_ent_nxt    = hit_ent;
            ctl.pull       = 1'b1;
            ctl.clr        = 1'b1;
            count_nxt      = count_r - CNT_W'(1);
            state_nxt      = S_IDLE;
          end
        end else if (!tok_live) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_MISS;
            out_ent_nxt    = '{handle: '0, pages: miss_pages};
            ctl.clr        = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else begin
          ctl.step = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.out_handle = out_ent_r.handle;
  assign out_ch.out_pages  = out_ent_r.pages;

  `FFBP_ASSERT(a_tok_onehot, clk, rst_n, $onehot0(tok), "more than one search token")
  `FFBP_ASSERT_ALWAYS(a_count_max, clk, !rst_n || (count_r <= CNT_W'(POOL_DEPTH)), "count overflow")
  `FFBP_ASSERT(a_hit_in_search, clk, rst_n, (|hit) |-> (state_r == S_SEARCH), "hit outside search")
  `FFBP_ASSERT(a_busy_after_fire, clk, rst_n, in_fire |=> (state_r != S_IDLE), "word dropped")
  `FFBP_ASSERT(a_idle_no_tok, clk, rst_n, (state_r == S_IDLE) |-> !(|tok), "stale token in idle")

endmodule
